// ===== design/utf8_blank_strip_fullwidth_fold_defines.svh =====
// Assertion macros used by the checker file of the blank strip block.
`ifndef UTF8_BLANK_STRIP_FULLWIDTH_FOLD_DEFINES_SVH
`define UTF8_BLANK_STRIP_FULLWIDTH_FOLD_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define UBS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define UBS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/utf8bsf_pkg.sv =====
// Types, constants and character helpers of the blank strip block.
`timescale 1ns / 1ps
package utf8bsf_pkg;

    localparam int BYTE_W         = 8;
    localparam int CHAR_MAX_BYTES = 6;
    localparam int LEN_W          = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Strip modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_AFTER = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] FOLD_HI_OFFSET = 8'h60;
    localparam logic [7:0] FOLD_LO_OFFSET = 8'h20;

    typedef logic [BYTE_W-1:0] byte_t;

    // One queued item: the bytes to send, how many, and the line end mark.
    typedef struct packed {
        logic [CHAR_MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [LEN_W-1:0]                      count;
        logic                                  line_end;
    } q_entry_t;

    // Character length from its lead byte, zero for an invalid lead.
    function automatic logic [LEN_W-1:0] lead_len(input byte_t b);
        logic [LEN_W-1:0] len;
        if (b < 8'h80)                    len = 3'd1;
        else if ((b & 8'he0) == 8'hc0)    len = 3'd2;
        else if ((b & 8'hf0) == 8'he0)    len = 3'd3;
        else if ((b & 8'hf8) == 8'hf0)    len = 3'd4;
        else if ((b & 8'hfc) == 8'hf8)    len = 3'd5;
        else if ((b & 8'hfe) == 8'hfc)    len = 3'd6;
        else                              len = 3'd0;
        return len;
    endfunction

    // ASCII byte of a fullwidth form, zero when the bytes are not one.
    function automatic byte_t fold_three(input byte_t a, input byte_t b, input byte_t c);
        byte_t f;
        f = 8'h00;
        if (a == 8'he3 && b == 8'h80 && c == 8'h80)
            f = CH_SPACE;
        else if (a == 8'hef && b == 8'hbc && (c inside {[8'h81:8'hbf]}))
            f = 8'(c - FOLD_HI_OFFSET);
        else if (a == 8'hef && b == 8'hbd && (c inside {[8'h80:8'h9e]}))
            f = 8'(c - FOLD_LO_OFFSET);
        return f;
    endfunction

    function automatic logic is_letter(input byte_t c);
        return (c inside {[8'h41:8'h5a], [8'h61:8'h7a]});
    endfunction

    function automatic logic is_blank(input byte_t c);
        return (c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF});
    endfunction

endpackage

// ===== design/utf8bsf_front.sv =====
// Front part: gathers characters, folds fullwidth forms, strips blanks.
`timescale 1ns / 1ps
module utf8bsf_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_take,
    input  utf8bsf_pkg::byte_t    in_byte,
    input  logic                  line_end,
    output logic                  push,
    output utf8bsf_pkg::q_entry_t entry
);
    import utf8bsf_pkg::*;

    byte_t            char_store [CHAR_MAX_BYTES];
    logic [LEN_W-1:0] char_length_reg, char_length_next;
    logic [LEN_W-1:0] bytes_held_reg, bytes_held_next;
    logic             prev_letter_reg, prev_letter_next;
    logic [1:0]       strip_mode_reg, strip_mode_next;

    logic [LEN_W-1:0] held_inc;
    logic [LEN_W-1:0] lead;
    byte_t            folded;
    byte_t            asc;
    logic             do_ascii;
    logic             keep;
    logic [LEN_W-1:0] emit_cnt;

    // Classify the incoming byte and work out what it emits
    always_comb begin
        held_inc         = 3'(bytes_held_reg + 3'd1);
        lead             = lead_len(in_byte);
        folded           = fold_three(char_store[0], char_store[1], in_byte);
        asc              = in_byte;
        do_ascii         = 1'b0;
        keep             = 1'b0;
        emit_cnt         = '0;
        char_length_next = char_length_reg;
        bytes_held_next  = bytes_held_reg;
        prev_letter_next = prev_letter_reg;
        strip_mode_next  = strip_mode_reg;

        if (bytes_held_reg == '0) begin
            if (in_byte == CH_SPACE &&
                (strip_mode_reg == MODE_START || strip_mode_reg == MODE_RUN)) begin
                // drop the space
            end else if (in_byte == CH_SPACE && !line_end) begin
                strip_mode_next = MODE_RUN;
            end else if (lead == 3'd0) begin
                strip_mode_next = MODE_AFTER;
            end else if (lead == 3'd1) begin
                do_ascii        = 1'b1;
                strip_mode_next = MODE_AFTER;
            end else begin
                char_length_next = lead;
                bytes_held_next  = 3'd1;
            end
        end else if (held_inc >= char_length_reg) begin
            // Character complete
            bytes_held_next  = '0;
            char_length_next = '0;
            strip_mode_next  = MODE_AFTER;
            if (char_length_reg == 3'd3 && folded != 8'h00) begin
                do_ascii = 1'b1;
                asc      = folded;
            end else begin
                emit_cnt = char_length_reg;
                if (char_length_reg == 3'd3) begin
                    prev_letter_next = 1'b0;
                end
            end
        end else begin
            bytes_held_next = held_inc;
        end

        // ASCII handling: a space survives only after a letter
        if (do_ascii) begin
            keep             = !is_blank(asc) || (asc == CH_SPACE && prev_letter_reg);
            emit_cnt         = keep ? 3'd1 : 3'd0;
            prev_letter_next = is_letter(asc);
        end

        // Line end returns to the line start state
        if (line_end) begin
            bytes_held_next  = '0;
            char_length_next = '0;
            prev_letter_next = 1'b0;
            strip_mode_next  = MODE_START;
        end
    end

    // Assemble the queue item
    always_comb begin
        for (int i = 0; i < CHAR_MAX_BYTES; i++) begin
            entry.bytes[i] = (3'(i) == bytes_held_reg) ? in_byte : char_store[i];
        end
        if (do_ascii) begin
            entry.bytes[0] = asc;
        end
        entry.count    = emit_cnt;
        entry.line_end = line_end;
        push           = in_take && (emit_cnt != '0 || line_end);
    end

    // Store the byte at its place in the character
    always_ff @(posedge aclk) begin
        if (in_take) begin
            char_store[bytes_held_reg] <= in_byte;
        end
    end

    // Advance the control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_length_reg <= '0;
            bytes_held_reg  <= '0;
            prev_letter_reg <= 1'b0;
            strip_mode_reg  <= MODE_START;
        end else if (in_take) begin
            char_length_reg <= char_length_next;
            bytes_held_reg  <= bytes_held_next;
            prev_letter_reg <= prev_letter_next;
            strip_mode_reg  <= strip_mode_next;
        end
    end

endmodule

// ===== design/utf8bsf_queue.sv =====
// Short queue of items between the front and back parts.
`timescale 1ns / 1ps
module utf8bsf_queue #(
    parameter int DEPTH = utf8bsf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  utf8bsf_pkg::q_entry_t push_entry,
    input  logic                  pop,
    output utf8bsf_pkg::q_entry_t head,
    output logic                  full,
    output logic                  empty
);
    import utf8bsf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t         slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    // Wrap the pointers and track the fill
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop) begin
            fill_next = CNT_W'(fill_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            fill_next = CNT_W'(fill_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== design/utf8bsf_back.sv =====
// Back part: sends the bytes of each queued item, one per cycle unless the output is stalled.
`timescale 1ns / 1ps
module utf8bsf_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  utf8bsf_pkg::q_entry_t head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output utf8bsf_pkg::byte_t    out_byte,
    output logic                  byte_valid,
    output logic                  line_done,
    output logic                  run_last
);
    import utf8bsf_pkg::*;

    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    byte_t            byte_reg, byte_next;
    logic             bvalid_reg, bvalid_next;
    logic             done_reg, done_next;
    logic             last_reg, last_next;

    logic             load;
    logic             take;
    logic             marker;
    logic             final_one;
    logic [LEN_W-1:0] idx_inc;

    // Load the output register when it is free or being taken
    always_comb begin
        load      = !valid_reg || out_ready;
        take      = load && !empty;
        marker    = (head.count == '0);
        idx_inc   = 3'(idx_reg + 3'd1);
        final_one = marker || (idx_inc == head.count);
        pop       = take && final_one;

        idx_next    = idx_reg;
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        bvalid_next = bvalid_reg;
        done_next   = done_reg;
        last_next   = last_reg;
        if (load) begin
            valid_next = !empty;
        end
        if (take) begin
            idx_next    = final_one ? '0 : idx_inc;
            byte_next   = marker ? 8'h00 : head.bytes[idx_reg];
            bvalid_next = !marker;
            done_next   = final_one && head.line_end;
            last_next   = final_one;
        end
    end

    // Payload holds while stalled
    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        bvalid_reg <= bvalid_next;
        done_reg   <= done_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign byte_valid = bvalid_reg;
    assign line_done  = done_reg;
    assign run_last   = last_reg;

endmodule

// ===== design/utf8_blank_strip_fullwidth_fold.sv =====
// Top level of the UTF-8 blank strip and fullwidth fold block.
//
//   channel | direction | tdata                          | tuser      | tlast
//   s_      | in        | [7:0] in_byte                  | -          | line_end
//   m_      | out       | [7:0] out_byte, [8] run_last   | byte_valid | line_done
//
// One input byte is taken every cycle while the item queue has room.
// One result leaves every cycle unless m_ stalls; n bytes give at most n results.
// A result passes the queue and the output register before it shows on m_.
// aresetn is synchronous and clears the character state, queue and output stage.
// A stalled output fills the queue; s_tready drops once it holds QUEUE_DEPTH items.
`timescale 1ns / 1ps
module utf8_blank_strip_fullwidth_fold #(
    parameter int QUEUE_DEPTH = utf8bsf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // line_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [8] run_last, [15:9] zero
    output logic        m_tuser,   // [0] byte_valid
    output logic        m_tlast    // line_done
);
    import utf8bsf_pkg::*;

    q_entry_t push_entry;
    q_entry_t head;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;
    logic     in_take;
    byte_t    out_byte;
    logic     run_last;

    assign s_tready = !full;
    assign in_take  = s_tvalid && !full;

    utf8bsf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_take  (in_take),
        .in_byte  (s_tdata),
        .line_end (s_tlast),
        .push     (push),
        .entry    (push_entry)
    );

    utf8bsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    utf8bsf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (out_byte),
        .byte_valid (m_tuser),
        .line_done  (m_tlast),
        .run_last   (run_last)
    );

    assign m_tdata = {7'd0, run_last, out_byte};

endmodule

// ===== design/utf8bsf_checker.sv =====
// Port checker of the blank strip block and its bind to the top level.
`timescale 1ns / 1ps
`include "utf8_blank_strip_fullwidth_fold_defines.svh"
module utf8bsf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    // A bare end marker closes the line, ends its run and carries a zero byte
    `UBS_ASSERT_NOW(a_marker_form, aclk, aresetn, m_tvalid && !m_tuser, m_tlast && m_tdata[8] && (m_tdata[7:0] == 8'h00), "bare end marker malformed")

    // The result that closes a line is always the last of its run
    `UBS_ASSERT_NOW(a_done_ends_run, aclk, aresetn, m_tvalid && m_tlast, m_tdata[8], "line end result not last of its run")

    // A stalled result holds
    `UBS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

endmodule

bind utf8_blank_strip_fullwidth_fold utf8bsf_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
